// ===== rtl/ppp_pkg.sv =====
// Shared types, widths and constants for the perspective point projector.
package ppp_pkg;

	localparam int COORD_W = 32;
	localparam int AXIS_W = 18;
	localparam int AXIS_PACK_W = 3 * AXIS_W;
	localparam int SCALE_W = 24;
	localparam int SCALE_FRAC = 16;
	localparam int DEF_COORD_FRAC = 16;
	localparam int PROD_W = COORD_W + 1 + AXIS_W;
	localparam int LAT_W = PROD_W + 2;
	localparam int MAG_LO_W = 27;
	localparam int QUOT_W = COORD_W + 1;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = AXIS_PACK_W;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_CAM_X = 4'd0,
		REG_CAM_Y = 4'd1,
		REG_CAM_Z = 4'd2,
		REG_AXIS_RIGHT = 4'd3,
		REG_AXIS_UP = 4'd4,
		REG_AXIS_FWD = 4'd5,
		REG_SCALE_X = 4'd6,
		REG_SCALE_Y = 4'd7
	} cfg_reg_t;

	localparam logic [AXIS_PACK_W-1:0] AXIS_RIGHT_RST = 54'd1 << SCALE_FRAC;
	localparam logic [AXIS_PACK_W-1:0] AXIS_UP_RST = 54'd1 << (SCALE_FRAC + AXIS_W);
	localparam logic [AXIS_PACK_W-1:0] AXIS_FWD_RST = 54'd1 << (SCALE_FRAC + 2 * AXIS_W);
	localparam logic [SCALE_W-1:0] SCALE_RST = 24'd1 << SCALE_FRAC;

	localparam logic [COORD_W-1:0] COORD_MAX = 32'h7FFF_FFFF;
	localparam logic [COORD_W-1:0] COORD_MIN = 32'h8000_0000;
	localparam logic [QUOT_W-1:0] LIMIT_POS = 33'h0_7FFF_FFFF;
	localparam logic [QUOT_W-1:0] LIMIT_NEG = 33'h0_8000_0000;

	typedef struct packed {
		logic behind;
		logic neg;
		logic nz;
	} lane_tag_t;

	function automatic logic signed [AXIS_W-1:0] axis_comp(
		input logic [AXIS_PACK_W-1:0] packed_axis,
		input int k
	);
		axis_comp = packed_axis[k * AXIS_W +: AXIS_W];
	endfunction

endpackage

// ===== rtl/ppp_dot.sv =====
// Camera offset and the three dot products against the view axes.
module ppp_dot import ppp_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid,
	input logic signed [COORD_W-1:0] world [3],
	input logic signed [COORD_W-1:0] cam [3],
	input logic [AXIS_PACK_W-1:0] axes [3],
	output logic valid_s3,
	output logic signed [LAT_W-1:0] lat_x_s3,
	output logic signed [LAT_W-1:0] lat_y_s3,
	output logic signed [LAT_W-1:0] depth_s3
);

	logic valid_s1, valid_s2;
	logic signed [COORD_W:0] d_s1 [3];
	logic signed [PROD_W-1:0] prod_s2 [3][3];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else if (en) begin
			valid_s1 <= valid;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < 3; k++) begin
				d_s1[k] <= (COORD_W+1)'(world[k]) - (COORD_W+1)'(cam[k]);
			end
			for (int a = 0; a < 3; a++) begin
				for (int k = 0; k < 3; k++) begin
					prod_s2[a][k] <= d_s1[k] * axis_comp(axes[a], k);
				end
			end
			lat_x_s3 <= LAT_W'(prod_s2[0][0]) + LAT_W'(prod_s2[0][1]) + LAT_W'(prod_s2[0][2]);
			lat_y_s3 <= LAT_W'(prod_s2[1][0]) + LAT_W'(prod_s2[1][1]) + LAT_W'(prod_s2[1][2]);
			depth_s3 <= LAT_W'(prod_s2[2][0]) + LAT_W'(prod_s2[2][1]) + LAT_W'(prod_s2[2][2]);
		end
	end

endmodule

// ===== rtl/ppp_mul.sv =====
// Magnitude, scale multiply and divisor alignment for both screen axes.
module ppp_mul import ppp_pkg::*; #(
	parameter int NUM_SHL = 0,
	parameter int DEN_SHL = 0,
	parameter int NUM_W = LAT_W + SCALE_W + NUM_SHL,
	parameter int DEN_W = LAT_W - 1 + DEN_SHL
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid,
	input logic signed [LAT_W-1:0] lat_x,
	input logic signed [LAT_W-1:0] lat_y,
	input logic signed [LAT_W-1:0] depth,
	input logic [SCALE_W-1:0] scale_x,
	input logic [SCALE_W-1:0] scale_y,
	output logic valid_s5,
	output logic [NUM_W-1:0] num_x_s5,
	output logic [NUM_W-1:0] num_y_s5,
	output logic [DEN_W-1:0] den_s5,
	output lane_tag_t tag_x_s5,
	output lane_tag_t tag_y_s5
);

	localparam int HI_W = LAT_W - MAG_LO_W;
	localparam int PM_W = LAT_W + SCALE_W;

	logic valid_s4;
	logic [LAT_W-1:0] mag_x, mag_y;
	logic [MAG_LO_W+SCALE_W-1:0] plo_x_s4, plo_y_s4;
	logic [HI_W+SCALE_W-1:0] phi_x_s4, phi_y_s4;
	logic [DEN_W-1:0] den_s4;
	lane_tag_t tag_x_s4, tag_y_s4;
	logic behind;

	assign mag_x = lat_x[LAT_W-1] ? LAT_W'(-lat_x) : LAT_W'(lat_x);
	assign mag_y = lat_y[LAT_W-1] ? LAT_W'(-lat_y) : LAT_W'(lat_y);
	assign behind = (depth[LAT_W-1] == 1'b1) || (depth == '0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else if (en) begin
			valid_s4 <= valid;
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			plo_x_s4 <= mag_x[MAG_LO_W-1:0] * scale_x;
			phi_x_s4 <= mag_x[LAT_W-1:MAG_LO_W] * scale_x;
			plo_y_s4 <= mag_y[MAG_LO_W-1:0] * scale_y;
			phi_y_s4 <= mag_y[LAT_W-1:MAG_LO_W] * scale_y;
			den_s4 <= DEN_W'(depth[LAT_W-2:0]) << DEN_SHL;
			tag_x_s4 <= '{behind: behind, neg: lat_x[LAT_W-1], nz: lat_x != '0};
			tag_y_s4 <= '{behind: behind, neg: lat_y[LAT_W-1], nz: lat_y != '0};

			num_x_s5 <= NUM_W'((PM_W'(phi_x_s4) << MAG_LO_W) + PM_W'(plo_x_s4)) << NUM_SHL;
			num_y_s5 <= NUM_W'((PM_W'(phi_y_s4) << MAG_LO_W) + PM_W'(plo_y_s4)) << NUM_SHL;
			den_s5 <= den_s4;
			tag_x_s5 <= tag_x_s4;
			tag_y_s5 <= tag_y_s4;
		end
	end

endmodule

// ===== rtl/ppp_div.sv =====
// Pipelined restoring divider, one quotient bit per stage, with overflow detect.
module ppp_div import ppp_pkg::*; #(
	parameter int NUM_W = LAT_W + SCALE_W,
	parameter int DEN_W = LAT_W - 1
) (
	input logic clk,
	input logic arst_n,
	input logic en,
	input logic valid,
	input logic [NUM_W-1:0] num,
	input logic [DEN_W-1:0] den,
	input lane_tag_t tag,
	output logic valid_out,
	output logic [QUOT_W-1:0] quot,
	output logic ovf,
	output lane_tag_t tag_out
);

	localparam int CMP_W = NUM_W + QUOT_W;
	localparam int TMP_W = NUM_W + DEN_W;

	logic valid_s [QUOT_W+1];
	logic [DEN_W-1:0] rem_s [QUOT_W+1];
	logic [DEN_W-1:0] den_s [QUOT_W+1];
	logic [QUOT_W-1:0] nlo_s [QUOT_W+1];
	logic [QUOT_W-1:0] quot_s [QUOT_W+1];
	logic ovf_s [QUOT_W+1];
	lane_tag_t tag_s [QUOT_W+1];
	logic [TMP_W-1:0] rem_init;

	assign rem_init = TMP_W'(num >> QUOT_W);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s[0] <= 1'b0;
		end else if (en) begin
			valid_s[0] <= valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			ovf_s[0] <= CMP_W'(num) >= (CMP_W'(den) << QUOT_W);
			rem_s[0] <= rem_init[DEN_W-1:0];
			den_s[0] <= den;
			nlo_s[0] <= num[QUOT_W-1:0];
			quot_s[0] <= '0;
			tag_s[0] <= tag;
		end
	end

	for (genvar k = 0; k < QUOT_W; k++) begin : g_stage
		logic [DEN_W:0] trial;
		logic [DEN_W:0] diff;
		logic take;

		assign trial = {rem_s[k], nlo_s[k][QUOT_W-1-k]};
		assign take = trial >= (DEN_W+1)'(den_s[k]);
		assign diff = trial - (DEN_W+1)'(den_s[k]);

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				valid_s[k+1] <= 1'b0;
			end else if (en) begin
				valid_s[k+1] <= valid_s[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
				quot_s[k+1] <= {quot_s[k][QUOT_W-2:0], take};
				den_s[k+1] <= den_s[k];
				nlo_s[k+1] <= nlo_s[k];
				ovf_s[k+1] <= ovf_s[k];
				tag_s[k+1] <= tag_s[k];
			end
		end
	end

	assign valid_out = valid_s[QUOT_W];
	assign quot = quot_s[QUOT_W];
	assign ovf = ovf_s[QUOT_W];
	assign tag_out = tag_s[QUOT_W];

endmodule

// ===== rtl/perspective_point_projector_top.sv =====
// Top level of the perspective point projector: registers, pipeline and output buffer.
//
// The block takes one world point per transfer on the input channel (in_valid,
// in_stall, world_x/y/z) and returns one screen point per transfer on the
// output channel (out_valid, out_stall, screen_x/y, behind_camera, saturated).
// Camera position, view axes and screen scales are loaded through the write
// channel (cfg_valid, cfg_ready, cfg_index, cfg_data); cfg_ready is always high
// and writes to indexes above seven are dropped. Load registers only while no
// point is in flight.
// From input transfer to presented result, a point passes five stages of offset,
// dot product and scale multiply, one stage of overflow check, 33 stages of the
// divider (one quotient bit each) and the output register. One point is accepted
// every cycle while in_stall is low.
// Reset empties the pipeline and the output buffer and loads the identity
// camera at the origin with unit scales.
// When the receiver stalls, the output register holds its result and a second
// buffer entry catches the next one; only then does in_stall rise, and the
// whole pipeline freezes until the buffer drains. No result is lost or repeated.
module perspective_point_projector_top import ppp_pkg::*; #(
	parameter int COORD_FRAC_BITS = DEF_COORD_FRAC
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_stall,
	input logic signed [COORD_W-1:0] world_x,
	input logic signed [COORD_W-1:0] world_y,
	input logic signed [COORD_W-1:0] world_z,
	output logic out_valid,
	input logic out_stall,
	output logic signed [COORD_W-1:0] screen_x,
	output logic signed [COORD_W-1:0] screen_y,
	output logic behind_camera,
	output logic saturated,
	input logic cfg_valid,
	output logic cfg_ready,
	input logic [CFG_IDX_W-1:0] cfg_index,
	input logic [CFG_DATA_W-1:0] cfg_data
);

	localparam int NUM_SHL = (COORD_FRAC_BITS >= SCALE_FRAC) ? COORD_FRAC_BITS - SCALE_FRAC : 0;
	localparam int DEN_SHL = (COORD_FRAC_BITS < SCALE_FRAC) ? SCALE_FRAC - COORD_FRAC_BITS : 0;
	localparam int NUM_W = LAT_W + SCALE_W + NUM_SHL;
	localparam int DEN_W = LAT_W - 1 + DEN_SHL;

	logic signed [COORD_W-1:0] cam_q [3];
	logic [AXIS_PACK_W-1:0] axes_q [3];
	logic [SCALE_W-1:0] scale_x_q, scale_y_q;
	logic signed [COORD_W-1:0] world [3];

	logic en;
	logic valid_s3, valid_s5, valid_x, valid_y;
	logic signed [LAT_W-1:0] lat_x_s3, lat_y_s3, depth_s3;
	logic [NUM_W-1:0] num_x_s5, num_y_s5;
	logic [DEN_W-1:0] den_s5;
	lane_tag_t tag_x_s5, tag_y_s5, tag_x, tag_y;
	logic [QUOT_W-1:0] quot_x, quot_y;
	logic ovf_x, ovf_y;

	logic signed [COORD_W-1:0] res_x, res_y;
	logic sat_x, sat_y;

	logic out_valid_q, skid_valid_q;
	logic signed [COORD_W-1:0] out_x_q, out_y_q, skid_x_q, skid_y_q;
	logic out_behind_q, out_sat_q, skid_behind_q, skid_sat_q;
	logic take;

	assign cfg_ready = 1'b1;
	assign world[0] = world_x;
	assign world[1] = world_y;
	assign world[2] = world_z;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cam_q[0] <= '0;
			cam_q[1] <= '0;
			cam_q[2] <= '0;
			axes_q[0] <= AXIS_RIGHT_RST;
			axes_q[1] <= AXIS_UP_RST;
			axes_q[2] <= AXIS_FWD_RST;
			scale_x_q <= SCALE_RST;
			scale_y_q <= SCALE_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_reg_t'(cfg_index))
				REG_CAM_X: cam_q[0] <= cfg_data[COORD_W-1:0];
				REG_CAM_Y: cam_q[1] <= cfg_data[COORD_W-1:0];
				REG_CAM_Z: cam_q[2] <= cfg_data[COORD_W-1:0];
				REG_AXIS_RIGHT: axes_q[0] <= cfg_data;
				REG_AXIS_UP: axes_q[1] <= cfg_data;
				REG_AXIS_FWD: axes_q[2] <= cfg_data;
				REG_SCALE_X: scale_x_q <= cfg_data[SCALE_W-1:0];
				REG_SCALE_Y: scale_y_q <= cfg_data[SCALE_W-1:0];
				default: ;
			endcase
		end
	end

	assign en = !skid_valid_q;
	assign in_stall = skid_valid_q;

	ppp_dot u_dot (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(in_valid),
		.world(world),
		.cam(cam_q),
		.axes(axes_q),
		.valid_s3(valid_s3),
		.lat_x_s3(lat_x_s3),
		.lat_y_s3(lat_y_s3),
		.depth_s3(depth_s3)
	);

	ppp_mul #(
		.NUM_SHL(NUM_SHL),
		.DEN_SHL(DEN_SHL),
		.NUM_W(NUM_W),
		.DEN_W(DEN_W)
	) u_mul (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(valid_s3),
		.lat_x(lat_x_s3),
		.lat_y(lat_y_s3),
		.depth(depth_s3),
		.scale_x(scale_x_q),
		.scale_y(scale_y_q),
		.valid_s5(valid_s5),
		.num_x_s5(num_x_s5),
		.num_y_s5(num_y_s5),
		.den_s5(den_s5),
		.tag_x_s5(tag_x_s5),
		.tag_y_s5(tag_y_s5)
	);

	ppp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_x (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(valid_s5),
		.num(num_x_s5),
		.den(den_s5),
		.tag(tag_x_s5),
		.valid_out(valid_x),
		.quot(quot_x),
		.ovf(ovf_x),
		.tag_out(tag_x)
	);

	ppp_div #(.NUM_W(NUM_W), .DEN_W(DEN_W)) u_div_y (
		.clk(clk),
		.arst_n(arst_n),
		.en(en),
		.valid(valid_s5),
		.num(num_y_s5),
		.den(den_s5),
		.tag(tag_y_s5),
		.valid_out(valid_y),
		.quot(quot_y),
		.ovf(ovf_y),
		.tag_out(tag_y)
	);

	always_comb begin
		logic [QUOT_W-1:0] lim_x, lim_y;
		lim_x = tag_x.neg ? LIMIT_NEG : LIMIT_POS;
		lim_y = tag_y.neg ? LIMIT_NEG : LIMIT_POS;
		if (tag_x.behind) begin
			res_x = tag_x.nz ? (tag_x.neg ? COORD_MIN : COORD_MAX) : '0;
			sat_x = tag_x.nz;
		end else if (ovf_x || quot_x > lim_x) begin
			res_x = tag_x.neg ? COORD_MIN : COORD_MAX;
			sat_x = 1'b1;
		end else begin
			res_x = tag_x.neg ? -quot_x[COORD_W-1:0] : quot_x[COORD_W-1:0];
			sat_x = 1'b0;
		end
		if (tag_y.behind) begin
			res_y = tag_y.nz ? (tag_y.neg ? COORD_MIN : COORD_MAX) : '0;
			sat_y = tag_y.nz;
		end else if (ovf_y || quot_y > lim_y) begin
			res_y = tag_y.neg ? COORD_MIN : COORD_MAX;
			sat_y = 1'b1;
		end else begin
			res_y = tag_y.neg ? -quot_y[COORD_W-1:0] : quot_y[COORD_W-1:0];
			sat_y = 1'b0;
		end
	end

	assign take = out_valid_q && !out_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_valid_q <= 1'b1;
				skid_valid_q <= 1'b0;
			end else begin
				out_valid_q <= en && valid_x && valid_y;
			end
		end else if (en && valid_x && valid_y) begin
			skid_valid_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take || !out_valid_q) begin
			if (skid_valid_q) begin
				out_x_q <= skid_x_q;
				out_y_q <= skid_y_q;
				out_behind_q <= skid_behind_q;
				out_sat_q <= skid_sat_q;
			end else begin
				out_x_q <= res_x;
				out_y_q <= res_y;
				out_behind_q <= tag_x.behind;
				out_sat_q <= sat_x || sat_y;
			end
		end else if (en) begin
			skid_x_q <= res_x;
			skid_y_q <= res_y;
			skid_behind_q <= tag_x.behind;
			skid_sat_q <= sat_x || sat_y;
		end
	end

	assign out_valid = out_valid_q;
	assign screen_x = out_x_q;
	assign screen_y = out_y_q;
	assign behind_camera = out_behind_q;
	assign saturated = out_sat_q;

endmodule

// ===== dv/tb_perspective_point_projector_top.sv =====
// Self-checking testbench for the perspective point projector with random flow control.
`timescale 1ns / 100ps

module tb_perspective_point_projector_top;
	import ppp_pkg::*;

	localparam int NUM_REGS = 8;
	localparam int RAND_POINTS = 1230;
	localparam int NUM_PHASES = 6;
	localparam int DRAIN_CYCLES = 60;
	localparam longint CYCLE_LIMIT = 1000000;
	localparam logic [COORD_W-1:0] ONE = 32'h0001_0000;

	typedef struct {
		logic [COORD_W-1:0] sx;
		logic [COORD_W-1:0] sy;
		logic behind;
		logic sat;
	} screen_pt_t;

	typedef struct {
		logic [COORD_W-1:0] x;
		logic [COORD_W-1:0] y;
		logic [COORD_W-1:0] z;
		bit known;
		screen_pt_t res;
	} point_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic signed [COORD_W-1:0] world_x = '0;
	logic signed [COORD_W-1:0] world_y = '0;
	logic signed [COORD_W-1:0] world_z = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic signed [COORD_W-1:0] screen_x;
	logic signed [COORD_W-1:0] screen_y;
	logic behind_camera;
	logic saturated;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	logic [COORD_W-1:0] cam_m[3];
	logic [AXIS_PACK_W-1:0] axis_m[3];
	logic [SCALE_W-1:0] scale_m[2];
	screen_pt_t screen_q[$];
	int errors = 0;
	longint cycles = 0;
	bit quiet = 0;
	int stall_left = 0;
	bit stall_on = 0;

	perspective_point_projector_top dut (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	task automatic report(input string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	function automatic logic [COORD_W-1:0] project_lane(input longint lat,
			input logic [SCALE_W-1:0] s, input longint depth, inout logic sat);
		logic [127:0] mag;
		logic [127:0] q;
		logic [127:0] lim;
		bit neg;
		neg = lat < 0;
		mag = neg ? 128'(-lat) : 128'(lat);
		if (mag == 0 || s == 0)
			return '0;
		q = (mag * 128'(s)) / 128'(depth);
		lim = neg ? 128'(LIMIT_NEG) : 128'(LIMIT_POS);
		if (q > lim) begin
			sat = 1'b1;
			q = lim;
		end
		return neg ? -q[COORD_W-1:0] : q[COORD_W-1:0];
	endfunction

	function automatic screen_pt_t project_point(input logic [COORD_W-1:0] x,
			input logic [COORD_W-1:0] y, input logic [COORD_W-1:0] z);
		longint d[3];
		longint dp[3];
		screen_pt_t r;
		logic sat;
		d[0] = longint'($signed(x)) - longint'($signed(cam_m[0]));
		d[1] = longint'($signed(y)) - longint'($signed(cam_m[1]));
		d[2] = longint'($signed(z)) - longint'($signed(cam_m[2]));
		for (int a = 0; a < 3; a++) begin
			dp[a] = 0;
			for (int k = 0; k < 3; k++)
				dp[a] += d[k] * longint'($signed(axis_m[a][k*AXIS_W +: AXIS_W]));
		end
		sat = 1'b0;
		r.behind = dp[2] <= 0;
		if (r.behind) begin
			r.sx = dp[0] > 0 ? COORD_MAX : (dp[0] < 0 ? COORD_MIN : '0);
			r.sy = dp[1] > 0 ? COORD_MAX : (dp[1] < 0 ? COORD_MIN : '0);
			sat = (dp[0] != 0) || (dp[1] != 0);
		end else begin
			r.sx = project_lane(dp[0], scale_m[0], dp[2], sat);
			r.sy = project_lane(dp[1], scale_m[1], dp[2], sat);
		end
		r.sat = sat;
		return r;
	endfunction

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
		bit done;
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = cfg_ready;
			@(posedge clk);
		end
		cfg_valid <= 1'b0;
		case (idx)
			REG_CAM_X, REG_CAM_Y, REG_CAM_Z: cam_m[idx] = val[COORD_W-1:0];
			REG_AXIS_RIGHT, REG_AXIS_UP, REG_AXIS_FWD: axis_m[idx - REG_AXIS_RIGHT] = val;
			REG_SCALE_X, REG_SCALE_Y: scale_m[idx - REG_SCALE_X] = val[SCALE_W-1:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic send_point(input logic [COORD_W-1:0] x, input logic [COORD_W-1:0] y,
			input logic [COORD_W-1:0] z, input bit known, input screen_pt_t res);
		bit done;
		int gap;
		gap = quiet ? 0 : ($urandom_range(9) < 7 ? $urandom_range(2) : $urandom_range(40, 10));
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		world_x <= x;
		world_y <= y;
		world_z <= z;
		done = 0;
		while (!done) begin
			@(negedge clk);
			done = !in_stall;
			@(posedge clk);
		end
		screen_q.push_back(known ? res : project_point(x, y, z));
	endtask

	task automatic wait_idle();
		in_valid <= 1'b0;
		while (screen_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	function automatic logic [COORD_W-1:0] rand_coord();
		case ($urandom_range(5))
			0, 1: return $urandom;
			2: return 32'($signed($urandom_range(32'h3FFFF))) - 32'h1FFFF;
			3: return $urandom_range(1) ? COORD_MAX : COORD_MIN;
			default: return cam_m[$urandom_range(2)] + (32'($urandom_range(32'h7FFFF)) - 32'h3FFFF);
		endcase
	endfunction

	function automatic logic [AXIS_PACK_W-1:0] rand_axis(input int mode);
		logic [AXIS_PACK_W-1:0] v;
		for (int k = 0; k < 3; k++)
			case (mode)
				0: v[k*AXIS_W +: AXIS_W] = {AXIS_W{1'b1}} >> 1;
				1: v[k*AXIS_W +: AXIS_W] = 18'h20000;
				default: v[k*AXIS_W +: AXIS_W] = 18'($urandom);
			endcase
		return v;
	endfunction

	always @(posedge clk) begin
		if (stall_left == 0) begin
			stall_on <= !quiet && $urandom_range(9) < 4;
			stall_left <= $urandom_range(9) == 0 ? $urandom_range(60, 20) : $urandom_range(6, 1);
			out_stall <= 1'b0;
		end else begin
			stall_left <= stall_left - 1;
			out_stall <= stall_on;
		end
	end

	always @(negedge clk) begin
		screen_pt_t e;
		if (arst_n && out_valid && !out_stall) begin
			if (screen_q.size() == 0) begin
				report("result transfer with nothing expected");
			end else begin
				e = screen_q.pop_front();
				if (screen_x !== e.sx)
					report($sformatf("screen_x %h expected %h", screen_x, e.sx));
				if (screen_y !== e.sy)
					report($sformatf("screen_y %h expected %h", screen_y, e.sy));
				if (behind_camera !== e.behind)
					report($sformatf("behind_camera %b expected %b", behind_camera, e.behind));
				if (saturated !== e.sat)
					report($sformatf("saturated %b expected %b", saturated, e.sat));
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("perspective_point_projector_top test failed");
			$finish;
		end
	end

	initial begin
		point_row_t rows[$];
		screen_pt_t none;
		none = '{default: '0};
		cam_m = '{'0, '0, '0};
		axis_m = '{AXIS_RIGHT_RST, AXIS_UP_RST, AXIS_FWD_RST};
		scale_m = '{SCALE_RST, SCALE_RST};
		rows = '{
			'{'0, '0, ONE, 1, '{'0, '0, 1'b0, 1'b0}},
			'{ONE, ONE, ONE, 1, '{ONE, ONE, 1'b0, 1'b0}},
			'{-ONE, -ONE, ONE, 1, '{-ONE, -ONE, 1'b0, 1'b0}},
			'{'0, '0, '0, 1, '{'0, '0, 1'b1, 1'b0}},
			'{ONE, '0, -ONE, 1, '{COORD_MAX, '0, 1'b1, 1'b1}},
			'{-ONE, -ONE, -ONE, 1, '{COORD_MIN, COORD_MIN, 1'b1, 1'b1}},
			'{COORD_MAX, '0, 32'd1, 1, '{COORD_MAX, '0, 1'b0, 1'b1}},
			'{COORD_MIN, COORD_MIN, 32'd1, 1, '{COORD_MIN, COORD_MIN, 1'b0, 1'b1}},
			'{COORD_MAX, COORD_MIN, COORD_MAX, 0, none},
			'{COORD_MIN, COORD_MAX, COORD_MIN, 0, none},
			'{32'h0000_8000, 32'hFFFF_4000, 32'h0003_0000, 0, none},
			'{32'h0123_4567, 32'h89AB_CDEF, 32'h0000_0001, 0, none},
			'{32'h0000_0001, 32'hFFFF_FFFF, COORD_MAX, 0, none},
			'{ONE, ONE, 32'h0000_0003, 0, none}
		};
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		foreach (rows[i])
			send_point(rows[i].x, rows[i].y, rows[i].z, rows[i].known, rows[i].res);
		for (int ph = 0; ph < NUM_PHASES; ph++) begin
			wait_idle();
			quiet = ph == 3;
			for (int r = REG_CAM_X; r <= REG_CAM_Z; r++)
				write_reg(CFG_IDX_W'(r),
					ph == 0 ? COORD_MAX : (ph == 1 ? COORD_MIN : CFG_DATA_W'($urandom)));
			for (int r = REG_AXIS_RIGHT; r <= REG_AXIS_FWD; r++)
				write_reg(CFG_IDX_W'(r), ph == 4 ? axis_m[r - REG_AXIS_RIGHT] : rand_axis(ph));
			write_reg(REG_SCALE_X, ph == 0 ? {SCALE_W{1'b1}} : (ph == 1 ? '0 : SCALE_W'($urandom)));
			write_reg(REG_SCALE_Y, ph == 0 ? {SCALE_W{1'b1}} : (ph == 1 ? '0 : SCALE_W'($urandom)));
			write_reg(CFG_IDX_W'(NUM_REGS + $urandom_range(NUM_REGS - 1)), CFG_DATA_W'($urandom));
			for (int n = 0; n < RAND_POINTS / NUM_PHASES; n++) begin
				if (n == 40 && ph == 2)
					while (screen_q.size() != 0) begin
						in_valid <= 1'b0;
						@(posedge clk);
					end
				send_point(rand_coord(), rand_coord(), rand_coord(), 0, none);
			end
		end
		wait_idle();
		if (errors == 0)
			$display("perspective_point_projector_top test passed");
		else
			$display("perspective_point_projector_top test failed");
		$finish;
	end

endmodule

// ===== filelist.f =====
rtl/ppp_pkg.sv
rtl/ppp_dot.sv
rtl/ppp_mul.sv
rtl/ppp_div.sv
rtl/perspective_point_projector_top.sv
dv/tb_perspective_point_projector_top.sv
